### src/bss_pkg.sv
// Shared types and constants for the bounded stack block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bss_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DATA_W        = 32;
   localparam int MODE_W        = 3;
   localparam int FILL_W        = 5;

   localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MAX     = 3'd4;

   localparam logic signed [DATA_W-1:0] DATA_NEG_ONE = {DATA_W{1'b1}};

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data_out;
      logic [FILL_W-1:0]        fill_level;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP_WAIT,
      S_SRCH,
      S_MAX,
      S_REV_RD_HI,
      S_REV_WR_LO,
      S_REV_WR_HI,
      S_FINISH
   } state_type;

   // Read address sources.
   typedef enum logic [2:0] {
      RA_TOP,
      RA_IDX_DN,
      RA_ZERO,
      RA_HI,
      RA_LO_NEXT
   } rd_sel_type;

   // Write address and data sources.
   typedef enum logic [1:0] {
      WR_PUSH,
      WR_SRCH,
      WR_REV_LO,
      WR_REV_HI
   } wr_sel_type;

   // Result held for the response register.
   typedef enum logic [2:0] {
      RES_OK,
      RES_EMPTY,
      RES_UNDER,
      RES_FULL,
      RES_NOTFOUND,
      RES_POP,
      RES_MAX
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        init_scan;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        idx_dec;
      logic        rev_step;
      logic        save;
      logic        max_upd;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        res_set;
      res_sel_type res_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              count_zero;
      logic              count_lt2;
      logic              full;
      logic              match;
      logic              idx_zero;
      logic              rev_more;
   } stat_type;

   localparam cmd_type CMD_IDLE = '{
      load_req:  1'b0,
      init_scan: 1'b0,
      rd_en:     1'b0,
      rd_sel:    RA_TOP,
      wr_en:     1'b0,
      wr_sel:    WR_PUSH,
      idx_dec:   1'b0,
      rev_step:  1'b0,
      save:      1'b0,
      max_upd:   1'b0,
      cnt_inc:   1'b0,
      cnt_dec:   1'b0,
      res_set:   1'b0,
      res_sel:   RES_OK,
      rsp_load:  1'b0
   };

endpackage

### src/bounded_stack_search_max_reverse.sv
// Bounded LIFO stack of signed 32-bit values with push, pop, search-update,
// reverse and maximum, one response item per request item. Entries live in a
// single-port-write, single-port-read memory with a registered read, so the
// scanning operations are paced by that port: search-update and maximum read
// the entries one at a time from the top down, and reverse swaps them pair by
// pair, working inward from both ends. A new request item is taken
// while the previous response still waits in its output register. Entries are
// not cleared at reset; only the fill count is.
// Depends on bss_pkg, bss_ctrl and bss_datapath.
module bounded_stack_search_max_reverse
   import bss_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   bss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

### src/bss_ctrl.sv
// Sequencing state machine of the bounded stack block.
// Depends on bss_pkg; drives commands into bss_datapath and reads its status.
module bss_ctrl
   import bss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_IDLE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.init_scan = 1'b1;
            cmd.res_set   = 1'b1;
            state_in      = S_FINISH;
            unique case (stat.mode)
               MODE_PUSH: begin
                  if (stat.full) begin
                     cmd.res_sel = RES_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_PUSH;
                     cmd.cnt_inc = 1'b1;
                     cmd.res_sel = RES_OK;
                  end
               end
               MODE_POP: begin
                  if (stat.count_zero) begin
                     cmd.res_sel = RES_UNDER;
                  end else begin
                     cmd.res_set = 1'b0;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RA_TOP;
                     state_in    = S_POP_WAIT;
                  end
               end
               MODE_SEARCH: begin
                  if (stat.count_zero) begin
                     cmd.res_sel = RES_NOTFOUND;
                  end else begin
                     cmd.res_set = 1'b0;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RA_TOP;
                     state_in    = S_SRCH;
                  end
               end
               MODE_REVERSE: begin
                  if (stat.count_lt2) begin
                     cmd.res_sel = RES_OK;
                  end else begin
                     cmd.res_set = 1'b0;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RA_ZERO;
                     state_in    = S_REV_RD_HI;
                  end
               end
               MODE_MAX: begin
                  if (stat.count_zero) begin
                     cmd.res_sel = RES_EMPTY;
                  end else begin
                     cmd.res_set = 1'b0;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RA_TOP;
                     state_in    = S_MAX;
                  end
               end
               default: begin
                  cmd.res_sel = RES_OK;
               end
            endcase
         end
         S_POP_WAIT: begin
            cmd.cnt_dec = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res_sel = RES_POP;
            state_in    = S_FINISH;
         end
         S_SRCH: begin
            // The read data always belongs to the entry at the scan index.
            if (stat.match) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_SRCH;
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_OK;
               state_in    = S_FINISH;
            end else if (stat.idx_zero) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_NOTFOUND;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RA_IDX_DN;
               cmd.idx_dec = 1'b1;
            end
         end
         S_MAX: begin
            cmd.max_upd = 1'b1;
            if (stat.idx_zero) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_MAX;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RA_IDX_DN;
               cmd.idx_dec = 1'b1;
            end
         end
         S_REV_RD_HI: begin
            cmd.save   = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_HI;
            state_in   = S_REV_WR_LO;
         end
         S_REV_WR_LO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REV_LO;
            state_in   = S_REV_WR_HI;
         end
         S_REV_WR_HI: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_REV_HI;
            cmd.rev_step = 1'b1;
            if (stat.rev_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_LO_NEXT;
               state_in   = S_REV_RD_HI;
            end else begin
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_OK;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            // The response register is refilled only once the previous item has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### src/bss_datapath.sv
// Storage and datapath of the bounded stack block: entry memory, fill count,
// scan pointers, running maximum and the response register. Depends on bss_pkg.
module bss_datapath
   import bss_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   output rsp_type  rsp_data,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];

   req_type                  req_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_ff, lo_ff, hi_ff;
   logic signed [DATA_W-1:0] rdata_ff, save_ff, max_ff, max_in;
   status_type               res_status_ff;
   logic signed [DATA_W-1:0] res_data_ff;
   rsp_type                  rsp_ff;

   logic [CW-1:0]     top_cnt;
   logic [AW-1:0]     top_addr, rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW:0]       lo_p2;
   logic              max_first;

   assign top_cnt  = count_ff - CW'(1);
   assign top_addr = top_cnt[AW-1:0];
   assign lo_p2    = {1'b0, lo_ff} + (AW+1)'(2);

   always_comb begin
      unique case (cmd.rd_sel)
         RA_TOP:     rd_addr = top_addr;
         RA_IDX_DN:  rd_addr = idx_ff - AW'(1);
         RA_ZERO:    rd_addr = '0;
         RA_HI:      rd_addr = hi_ff;
         RA_LO_NEXT: rd_addr = lo_ff + AW'(1);
         default:    rd_addr = top_addr;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_PUSH: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = req_ff.value;
         end
         WR_SRCH: begin
            wr_addr = idx_ff;
            wr_data = req_ff.new_value;
         end
         WR_REV_LO: begin
            wr_addr = lo_ff;
            wr_data = rdata_ff;
         end
         WR_REV_HI: begin
            wr_addr = hi_ff;
            wr_data = save_ff;
         end
         default: begin
            wr_addr = lo_ff;
            wr_data = rdata_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // The first entry of a scan is the top one and seeds the maximum.
   assign max_first = (idx_ff == top_addr);
   assign max_in    = (max_first || (rdata_ff > max_ff)) ? rdata_ff : max_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = top_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.init_scan) begin
         idx_ff <= top_addr;
         lo_ff  <= '0;
         hi_ff  <= top_addr;
      end else begin
         if (cmd.idx_dec) begin
            idx_ff <= idx_ff - AW'(1);
         end
         if (cmd.rev_step) begin
            lo_ff <= lo_ff + AW'(1);
            hi_ff <= hi_ff - AW'(1);
         end
      end
      if (cmd.save) begin
         save_ff <= rdata_ff;
      end
      if (cmd.max_upd) begin
         max_ff <= max_in;
      end
      if (cmd.res_set) begin
         unique case (cmd.res_sel)
            RES_OK: begin
               res_status_ff <= ST_OK;
               res_data_ff   <= '0;
            end
            RES_EMPTY: begin
               res_status_ff <= ST_EMPTY;
               res_data_ff   <= '0;
            end
            RES_UNDER: begin
               res_status_ff <= ST_EMPTY;
               res_data_ff   <= DATA_NEG_ONE;
            end
            RES_FULL: begin
               res_status_ff <= ST_FULL;
               res_data_ff   <= '0;
            end
            RES_NOTFOUND: begin
               res_status_ff <= ST_NOTFOUND;
               res_data_ff   <= '0;
            end
            RES_POP: begin
               res_status_ff <= ST_OK;
               res_data_ff   <= rdata_ff;
            end
            RES_MAX: begin
               res_status_ff <= ST_OK;
               res_data_ff   <= max_in;
            end
            default: begin
               res_status_ff <= ST_OK;
               res_data_ff   <= '0;
            end
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_ff.status     <= res_status_ff;
         rsp_ff.data_out   <= res_data_ff;
         rsp_ff.fill_level <= FILL_W'(count_ff);
      end
   end

   assign rsp_data = rsp_ff;

   assign stat.mode       = req_ff.mode;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_lt2  = (count_ff < CW'(2));
   assign stat.full       = (count_ff >= CW'(DEPTH));
   assign stat.match      = (rdata_ff == req_ff.value);
   assign stat.idx_zero   = (idx_ff == '0);
   assign stat.rev_more   = (lo_p2 < {1'b0, hi_ff});

endmodule
